[rtl/dxt_texture_block_decoder_top_assert.svh]
// assertion macros for the texture block decoder
// expects clk and rst_n in the scope where the macros are used
`ifndef DXT_TEXTURE_BLOCK_DECODER_TOP_ASSERT_SVH
`define DXT_TEXTURE_BLOCK_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define DXT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dxt decoder check failed");

// next-cycle implication
`define DXT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dxt decoder check failed");

`endif

[rtl/dxt_pkg.sv]
// shared types and constants for the texture block decoder
// no dependencies
package dxt_pkg;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2,
    FMT_ARGB = 2'd3
  } fmt_t;

  localparam int TEXELS   = 16;
  localparam int CNT_W    = 4;
  localparam int IN_W     = 128;
  localparam int OUT_W    = 40;
  localparam int AIDX_LSB = 16;

  // decoded block: colour entries hold r in 7:0, g in 15:8, b in 23:16
  typedef struct packed {
    fmt_t                fmt;
    logic [3:0][23:0]    col;
    logic [3:0][7:0]     col_a;
    logic [7:0][7:0]     ap;
    logic [31:0]         cidx;
    logic [63:0]         aw;
  } blk_t;

endpackage

[rtl/dxt_texture_block_decoder_top.sv]
// top level of the S3TC texture block decoder with uncompressed pass-through
// depends on dxt_pkg, dxt_palette and dxt_emit
//
// Decodes one 4x4 compressed block per input item (DXT1, DXT3 or DXT5, chosen by the
// format register) into 16 RGBA texels, in row order with the last one flagged on tlast;
// in ARGB32 mode each item yields one reordered pixel. On accept the palettes are built
// and stored in the block register, then one texel per cycle, while out_tready does not
// stall the output, leaves through the output register; the next item is taken in the
// cycle its predecessor's last texel is issued. After accept the first texel passes the
// block register and then the output register. The format is sampled when an item is
// accepted and should be written only while the decoder is idle.
module dxt_texture_block_decoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration: texture format
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_data,
  // blocks in
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [dxt_pkg::IN_W-1:0]    in_tdata,   // color_word, alpha_word
  // texels out
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [dxt_pkg::OUT_W-1:0]   out_tdata,  // red, green, blue, alpha, texel_x, texel_y
  output logic                        out_tlast
);
  import dxt_pkg::*;

  fmt_t fmt_r, fmt_nxt;
  blk_t blk;

  assign cfg_ready = 1'b1;

  always_comb begin
    fmt_nxt = fmt_r;
    if (cfg_valid && cfg_ready) begin
      fmt_nxt = fmt_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_DXT1;
    end else begin
      fmt_r <= fmt_nxt;
    end
  end

  dxt_palette u_palette (
    .color_word (in_tdata[63:0]),
    .alpha_word (in_tdata[127:64]),
    .fmt        (fmt_r),
    .blk        (blk)
  );

  dxt_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .blk_in     (blk),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/dxt_palette.sv]
// builds the colour and alpha palettes of one block from the raw words
// depends on dxt_pkg
module dxt_palette (
  input  logic [63:0]   color_word,
  input  logic [63:0]   alpha_word,
  input  dxt_pkg::fmt_t fmt,
  output dxt_pkg::blk_t blk
);
  import dxt_pkg::*;

  localparam logic [10:0] DIV3_MUL = 11'd683;
  localparam logic [11:0] DIV7_MUL = 12'd2341;
  localparam logic [10:0] DIV5_MUL = 11'd1639;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [2:0] corr;
    begin
      corr = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
           + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
      widen5 = {v, 3'b000} + 8'(corr);
    end
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [1:0] corr;
    begin
      corr = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
      widen6 = {v, 2'b00} + 8'(corr);
    end
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    begin
      p    = 21'(x) * 21'(DIV3_MUL);
      div3 = p[18:11];
    end
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    begin
      p    = 22'(x) * 22'(DIV5_MUL);
      div5 = p[20:13];
    end
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    begin
      p    = 23'(x) * 23'(DIV7_MUL);
      div7 = p[21:14];
    end
  endfunction

  logic [15:0] c0, c1;
  logic [7:0]  a0, a1;
  logic        three_col;
  logic [23:0] e0, e1;
  logic [7:0]  ch0, ch1;

  assign c0        = color_word[15:0];
  assign c1        = color_word[31:16];
  assign a0        = alpha_word[7:0];
  assign a1        = alpha_word[15:8];
  assign three_col = (fmt == FMT_DXT1) && (c0 <= c1);
  assign e0        = {widen5(c0[4:0]), widen6(c0[10:5]), widen5(c0[15:11])};
  assign e1        = {widen5(c1[4:0]), widen6(c1[10:5]), widen5(c1[15:11])};

  always_comb begin
    blk        = '0;
    ch0        = '0;
    ch1        = '0;
    blk.fmt    = fmt;
    blk.cidx   = color_word[63:32];
    blk.aw     = alpha_word;
    blk.col[0] = e0;
    blk.col[1] = e1;
    for (int ch = 0; ch < 3; ch++) begin
      ch0 = e0[8*ch +: 8];
      ch1 = e1[8*ch +: 8];
      if (three_col) begin
        blk.col[2][8*ch +: 8] = 8'((9'(ch0) + 9'(ch1)) >> 1);
        blk.col[3][8*ch +: 8] = 8'd0;
      end else begin
        blk.col[2][8*ch +: 8] = div3(10'({ch0, 1'b0}) + 10'(ch1));
        blk.col[3][8*ch +: 8] = div3(10'(ch0) + 10'({ch1, 1'b0}));
      end
    end
    blk.col_a = {4{8'hFF}};
    if (three_col) begin
      blk.col_a[3] = 8'd0;
    end

    // interpolated alpha palette
    blk.ap[0] = a0;
    blk.ap[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) begin
        blk.ap[i+1] = div7(11'(7 - i) * 11'(a0) + 11'(i) * 11'(a1));
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        blk.ap[i+1] = div5(11'(5 - i) * 11'(a0) + 11'(i) * 11'(a1));
      end
      blk.ap[6] = 8'd0;
      blk.ap[7] = 8'hFF;
    end

    // uncompressed pixel sits in entry 0 with index 0
    if (fmt == FMT_ARGB) begin
      blk.cidx     = '0;
      blk.col[0]   = color_word[31:8];
      blk.col_a[0] = color_word[7:0];
    end
  end

endmodule

[rtl/dxt_emit.sv]
// holds one decoded block and issues its texels into the output register
// depends on dxt_pkg and the assertion macro header
module dxt_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  dxt_pkg::blk_t               blk_in,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [dxt_pkg::OUT_W-1:0]   out_tdata,
  output logic                        out_tlast
);
  import dxt_pkg::*;
  `include "dxt_texture_block_decoder_top_assert.svh"

  blk_t             blk_r, blk_nxt;
  logic             blk_valid_r, blk_valid_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic             load_en, issue, final_tx, accept;
  logic [1:0]       ci;
  logic [3:0]       nib;
  logic [5:0]       abit;
  logic [2:0]       ai;
  logic [7:0]       alpha;

  assign load_en   = !out_valid_r || out_tready;
  assign issue     = blk_valid_r && load_en;
  assign final_tx  = (blk_r.fmt == FMT_ARGB) || (cnt_r == CNT_W'(TEXELS - 1));
  assign in_tready = !blk_valid_r || (issue && final_tx);
  assign accept    = in_tvalid && in_tready;

  // texel select
  assign ci   = blk_r.cidx[{cnt_r, 1'b0} +: 2];
  assign nib  = blk_r.aw[{cnt_r, 2'b00} +: 4];
  assign abit = 6'(AIDX_LSB) + 6'({cnt_r, 1'b0}) + 6'(cnt_r);
  assign ai   = blk_r.aw[abit +: 3];

  always_comb begin
    unique case (blk_r.fmt)
      FMT_DXT3: alpha = {nib, nib};
      FMT_DXT5: alpha = blk_r.ap[ai];
      FMT_DXT1,
      FMT_ARGB: alpha = blk_r.col_a[ci];
    endcase
  end

  always_comb begin
    blk_nxt       = blk_r;
    blk_valid_nxt = blk_valid_r;
    cnt_nxt       = cnt_r;
    if (accept) begin
      blk_nxt       = blk_in;
      blk_valid_nxt = 1'b1;
      cnt_nxt       = '0;
    end else if (issue && final_tx) begin
      blk_valid_nxt = 1'b0;
    end else if (issue) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (issue) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'b0000, cnt_r[3:2], cnt_r[1:0], alpha, blk_r.col[ci]};
      out_last_nxt  = final_tx;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      blk_valid_r <= blk_valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `DXT_ASSERT_NOW(a_accept_only_at_end, accept && blk_valid_r, issue && final_tx)
  `DXT_ASSERT_NOW(a_argb_single, blk_valid_r && blk_r.fmt == FMT_ARGB, cnt_r == '0)
  `DXT_ASSERT_NEXT(a_last_marked, issue && final_tx, out_valid_r && out_last_r)
  `DXT_ASSERT_NEXT(a_count_steps, issue && !final_tx,
                   blk_valid_r && cnt_r == CNT_W'($past(cnt_r) + CNT_W'(1)))

endmodule
